@@ rtl/hdm_pkg.sv @@
`default_nettype none

package hdm_pkg;

    localparam int NumCols   = 4;
    localparam int NumLayers = 16;
    localparam int GroupSize = 4;
    localparam int SampleW   = 16;
    localparam int AccW      = 20;
    localparam int CoefW     = 16;
    localparam int MaskW     = 16;

    localparam logic [1:0] LastRow   = 2'd3;
    localparam logic [1:0] LastGroup = 2'd3;
    localparam logic [MaskW-1:0] MaskReset = 16'hFFFF;

    typedef logic signed [SampleW-1:0] sample_t;
    typedef sample_t [NumCols-1:0]     row_t;
    typedef logic signed [AccW-1:0]    acc_t;
    typedef acc_t [NumLayers-1:0]      acc_vec_t;
    typedef logic signed [CoefW-1:0]   coef_t;
    typedef logic [MaskW-1:0]          mask_t;

    // Merge stage status seen by the input side.
    typedef struct packed {
        logic busy;       // a block of results is waiting or draining
        logic last_going; // final group leaves this cycle
    } hdm_merge_stat_t;

    // Minus sign for sample (col, row) in layer: odd parity of layer & sel.
    function automatic logic neg_sign(input logic [3:0] layer, input logic [1:0] row,
                                      input logic [1:0] col);
        logic [3:0] sel;
        sel = {row[0], col[0], row[1], col[1]};
        return ^(layer & sel);
    endfunction

    // Divide by 16 truncating toward zero.
    function automatic coef_t trunc_div16(input acc_t x);
        acc_t biased;
        biased = x + (x[AccW-1] ? acc_t'(15) : acc_t'(0));
        return biased[AccW-1:AccW-CoefW];
    endfunction

endpackage

`default_nettype wire

@@ rtl/hdm_row_if.sv @@
`default_nettype none

interface hdm_row_if;
    logic             valid;
    logic             ready;
    hdm_pkg::sample_t sample_col0;
    hdm_pkg::sample_t sample_col1;
    hdm_pkg::sample_t sample_col2;
    hdm_pkg::sample_t sample_col3;

    modport source (output valid, output sample_col0, output sample_col1,
                    output sample_col2, output sample_col3, input ready);
    modport sink   (input valid, input sample_col0, input sample_col1,
                    input sample_col2, input sample_col3, output ready);
endinterface

`default_nettype wire

@@ rtl/hdm_coef_if.sv @@
`default_nettype none

interface hdm_coef_if;
    logic           valid;
    logic           ready;
    logic [1:0]     group_index;
    hdm_pkg::coef_t coef_a;
    hdm_pkg::coef_t coef_b;
    hdm_pkg::coef_t coef_c;
    hdm_pkg::coef_t coef_d;
    logic           last_of_block;

    modport source (output valid, output group_index, output coef_a, output coef_b,
                    output coef_c, output coef_d, output last_of_block, input ready);
    modport sink   (input valid, input group_index, input coef_a, input coef_b,
                    input coef_c, input coef_d, input last_of_block, output ready);
endinterface

`default_nettype wire

@@ rtl/hdm_lane.sv @@
`default_nettype none

// One coefficient layer: signed sum of the row's four samples into a running total.
module hdm_lane (
    input  wire logic          clk,
    input  wire logic [3:0]    layer,
    input  wire logic [1:0]    row_idx,
    input  wire hdm_pkg::row_t samples,
    input  wire logic          step,
    output hdm_pkg::acc_t      sum_next
);

    hdm_pkg::acc_t acc_reg;
    hdm_pkg::acc_t base;
    hdm_pkg::acc_t terms [hdm_pkg::NumCols];

    always_comb
    begin
        for (int c = 0; c < hdm_pkg::NumCols; c++)
        begin
            terms[c] = hdm_pkg::acc_t'(samples[c]);
            if (hdm_pkg::neg_sign(layer, row_idx, 2'(c)))
            begin
                terms[c] = -terms[c];
            end
        end
    end

    // Row 0 starts a fresh block.
    assign base     = (row_idx == 2'd0) ? '0 : acc_reg;
    assign sum_next = base + terms[0] + terms[1] + terms[2] + terms[3];

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            acc_reg <= sum_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/hdm_merge.sv @@
`default_nettype none

// Holds a finished block's sums and drains them as four coefficient groups.
module hdm_merge (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire hdm_pkg::acc_vec_t sums,
    input  wire hdm_pkg::mask_t    mask,
    output hdm_pkg::hdm_merge_stat_t stat,
    hdm_coef_if.source             coefs
);

    hdm_pkg::acc_t buf_reg [hdm_pkg::NumLayers];
    logic          busy_reg, busy_next;
    logic [1:0]    grp_reg, grp_next;
    logic          out_fire;

    assign out_fire = busy_reg && coefs.ready;

    always_comb
    begin
        busy_next = busy_reg;
        grp_next  = grp_reg;
        if (out_fire)
        begin
            grp_next = grp_reg + 2'd1;
            if (grp_reg == hdm_pkg::LastGroup)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            grp_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            grp_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            grp_reg  <= grp_next;
        end
    end

    // Disabled layers are stored as zero.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int l = 0; l < hdm_pkg::NumLayers; l++)
            begin
                buf_reg[l] <= mask[l] ? sums[l] : '0;
            end
        end
    end

    assign stat.busy       = busy_reg;
    assign stat.last_going = out_fire && (grp_reg == hdm_pkg::LastGroup);

    assign coefs.valid         = busy_reg;
    assign coefs.group_index   = grp_reg;
    assign coefs.coef_a        = hdm_pkg::trunc_div16(buf_reg[{grp_reg, 2'd0}]);
    assign coefs.coef_b        = hdm_pkg::trunc_div16(buf_reg[{grp_reg, 2'd1}]);
    assign coefs.coef_c        = hdm_pkg::trunc_div16(buf_reg[{grp_reg, 2'd2}]);
    assign coefs.coef_d        = hdm_pkg::trunc_div16(buf_reg[{grp_reg, 2'd3}]);
    assign coefs.last_of_block = (grp_reg == hdm_pkg::LastGroup);

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (load && busy_reg) |-> (out_fire && grp_reg == hdm_pkg::LastGroup))
        else $error("block loaded over undelivered results");

    a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (busy_reg && grp_reg == 2'd0))
        else $error("load did not restart at group 0");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !out_fire) |=> (busy_reg && $stable(grp_reg)))
        else $error("group pointer moved without a transaction");

    a_drain_complete: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> ($past(grp_reg) == hdm_pkg::LastGroup))
        else $error("results dropped before final group");

endmodule

`default_nettype wire

@@ rtl/hadamard_4x4_residual_transform.sv @@
`default_nettype none

// Channel  | Dir | Payload                                     | Transaction
// rows     | in  | sample_col0..3 (s16)                        | one block row
// coefs    | out | group_index, coef_a..d (s16), last_of_block | four layers
// cfg      | in  | cfg_wdata = layer_enable_mask (u16)         | cfg_we high
//
// Rows are taken one per cycle while rows.ready is high; sixteen layer lanes
// each add the row's signed samples to their running sum in the same cycle.
// The fourth row loads the block into the merge buffer, which then drives four
// result transactions, one per cycle while coefs.ready is high.
// A fourth row waits only while the buffer still holds an earlier block; at full
// rate the drain of one block overlaps all four rows of the next.
// Reset (rst_n low, asynchronous) sets row 0, empties the buffer, mask to 0xFFFF.
module hadamard_4x4_residual_transform (
    input  wire logic            clk,
    input  wire logic            rst_n,
    hdm_row_if.sink              rows,
    hdm_coef_if.source           coefs,
    input  wire logic            cfg_we,
    input  wire hdm_pkg::mask_t  cfg_wdata
);

    hdm_pkg::mask_t           mask_reg;
    logic [1:0]               row_reg, row_next;
    logic                     row_fire;
    logic                     block_done;
    hdm_pkg::row_t            samples;
    hdm_pkg::acc_vec_t        sums;
    hdm_pkg::hdm_merge_stat_t mstat;

    // A last row needs the buffer free, or freeing this cycle.
    assign rows.ready = (row_reg != hdm_pkg::LastRow) || !mstat.busy || mstat.last_going;
    assign row_fire   = rows.valid && rows.ready;
    assign block_done = row_fire && (row_reg == hdm_pkg::LastRow);

    assign samples[0] = rows.sample_col0;
    assign samples[1] = rows.sample_col1;
    assign samples[2] = rows.sample_col2;
    assign samples[3] = rows.sample_col3;

    assign row_next = row_fire ? row_reg + 2'd1 : row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= 2'd0;
            mask_reg <= hdm_pkg::MaskReset;
        end
        else
        begin
            row_reg <= row_next;
            if (cfg_we)
            begin
                mask_reg <= cfg_wdata;
            end
        end
    end

    // One lane per coefficient layer.
    for (genvar l = 0; l < hdm_pkg::NumLayers; l++)
    begin : g_lane
        hdm_lane u_lane (
            .clk      (clk),
            .layer    (4'(l)),
            .row_idx  (row_reg),
            .samples  (samples),
            .step     (row_fire),
            .sum_next (sums[l])
        );
    end

    hdm_merge u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (block_done),
        .sums  (sums),
        .mask  (mask_reg),
        .stat  (mstat),
        .coefs (coefs)
    );

endmodule

`default_nettype wire
